@@ design/sdf_pkg.sv @@
package sdf_pkg;

    // ascii codes used in the field
    localparam logic [6:0] CH_SPACE = 7'h20;
    localparam logic [6:0] CH_ZERO  = 7'h30;
    localparam logic [6:0] CH_MINUS = 7'h2D;
    localparam logic [6:0] CH_NUL   = 7'h00;

    localparam int CHAR_W   = 7;
    localparam int NUMBER_W = 32;
    localparam int FWIDTH_W = 5;

    // reciprocal of ten for a 32-bit dividend: q = (x * RECIP10) >> RECIP_SHIFT
    localparam logic [31:0] RECIP10     = 32'hCCCC_CCCD;
    localparam int          RECIP_SHIFT = 35;

    // queue status seen by the front and back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

@@ design/signed_decimal_field_formatter.sv @@
// conversion: the front takes a number while idle, builds one digit per cycle with the
//   reciprocal-multiply divider, then pushes the field to the queue for the back end to load
// output: the back end sends one character per cycle while m_tready is high; the front takes
//   a new number only once the last is pushed, and the two-entry queue lets conversion run ahead
// reset: aresetn synchronous active low, clears the sequencer, queue and output valid
module signed_decimal_field_formatter #(
    parameter int FIELD_LEN = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [31:0] number, [36:32] field_width, [39:37] zero
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,   // [6:0] character, [7] zero
    output logic        m_tlast
);

    localparam int POS_W   = $clog2(FIELD_LEN);
    localparam int WCNT_W  = $clog2(FIELD_LEN + 1);
    localparam int FIELD_W = FIELD_LEN * sdf_pkg::CHAR_W;
    localparam int ENTRY_W = FIELD_W + WCNT_W;

    sdf_pkg::q_status_t                         q_stat;
    logic                                       push;
    logic                                       pop;
    logic [WCNT_W-1:0]                          push_width;
    logic [FIELD_LEN-1:0][sdf_pkg::CHAR_W-1:0]  push_field;
    logic [ENTRY_W-1:0]                         head_data;
    logic [FIELD_LEN-1:0][sdf_pkg::CHAR_W-1:0]  head_field;
    logic [WCNT_W-1:0]                          head_width;
    logic [sdf_pkg::CHAR_W-1:0]                 out_char;

    assign head_field = head_data[FIELD_W-1:0];
    assign head_width = head_data[ENTRY_W-1:FIELD_W];
    assign m_tdata    = {1'b0, out_char};

    sdf_front #(
        .FIELD_LEN (FIELD_LEN),
        .POS_W     (POS_W),
        .WCNT_W    (WCNT_W)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_number  (s_tdata[31:0]),
        .in_width   (s_tdata[36:32]),
        .q_stat     (q_stat),
        .push       (push),
        .push_width (push_width),
        .push_field (push_field)
    );

    sdf_queue #(
        .ENTRY_W (ENTRY_W)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (push),
        .push_data ({push_width, push_field}),
        .pop       (pop),
        .head_data (head_data),
        .q_stat    (q_stat)
    );

    sdf_back #(
        .FIELD_LEN (FIELD_LEN),
        .POS_W     (POS_W),
        .WCNT_W    (WCNT_W)
    ) u_back (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .q_stat     (q_stat),
        .head_width (head_width),
        .head_field (head_field),
        .pop        (pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_char   (out_char),
        .out_last   (m_tlast)
    );

endmodule

@@ design/sdf_front.sv @@
module sdf_front #(
    parameter int FIELD_LEN = 16,
    parameter int POS_W     = $clog2(FIELD_LEN),
    parameter int WCNT_W    = $clog2(FIELD_LEN + 1)
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  logic                                        in_valid,
    output logic                                        in_ready,
    input  logic [sdf_pkg::NUMBER_W-1:0]                in_number,
    input  logic [sdf_pkg::FWIDTH_W-1:0]                in_width,
    input  sdf_pkg::q_status_t                          q_stat,
    output logic                                        push,
    output logic [WCNT_W-1:0]                           push_width,
    output logic [FIELD_LEN-1:0][sdf_pkg::CHAR_W-1:0]   push_field
);

    localparam logic [1:0] F_IDLE = 2'd0;
    localparam logic [1:0] F_CONV = 2'd1;
    localparam logic [1:0] F_PUSH = 2'd2;

    logic [1:0]                                 state_reg, state_next;
    logic [31:0]                                mag_reg, mag_next;
    logic                                       neg_reg, neg_next;
    logic [POS_W-1:0]                           pos_reg, pos_next;
    logic [WCNT_W-1:0]                          width_reg, width_next;
    logic [FIELD_LEN-1:0][sdf_pkg::CHAR_W-1:0]  field_reg, field_next;

    logic [63:0] prod;
    logic [31:0] quot;
    logic [31:0] quot_x10;
    logic [3:0]  rem;

    // one decimal digit per cycle by reciprocal multiply
    assign prod     = {32'd0, mag_reg} * {32'd0, sdf_pkg::RECIP10};
    assign quot     = 32'(prod[63:sdf_pkg::RECIP_SHIFT]);
    assign quot_x10 = (quot << 3) + (quot << 1);
    assign rem      = 4'(mag_reg - quot_x10);

    assign in_ready   = (state_reg == F_IDLE);
    assign push       = (state_reg == F_PUSH) && (width_reg != '0) && !q_stat.full;
    assign push_width = width_reg;
    assign push_field = field_reg;

    // sequencer and field build
    always_comb begin
        state_next = state_reg;
        mag_next   = mag_reg;
        neg_next   = neg_reg;
        pos_next   = pos_reg;
        width_next = width_reg;
        field_next = field_reg;
        unique case (state_reg)
            F_IDLE: begin
                if (in_valid) begin
                    neg_next = in_number[31];
                    mag_next = in_number[31] ? (~in_number + 32'd1) : in_number;
                    pos_next = '0;
                    if (int'(in_width) > FIELD_LEN) begin
                        width_next = WCNT_W'(FIELD_LEN);
                    end else begin
                        width_next = WCNT_W'(in_width);
                    end
                    for (int k = 0; k < FIELD_LEN; k++) begin
                        field_next[k] = (k == FIELD_LEN - 1) ? sdf_pkg::CH_NUL
                                                             : sdf_pkg::CH_SPACE;
                    end
                    state_next = F_CONV;
                end
            end
            F_CONV: begin
                field_next[pos_reg] = sdf_pkg::CH_ZERO + {3'd0, rem};
                mag_next = quot;
                pos_next = pos_reg + 1'b1;
                if (quot == 32'd0) begin
                    if (neg_reg) begin
                        field_next[pos_reg + 1'b1] = sdf_pkg::CH_MINUS;
                    end
                    state_next = F_PUSH;
                end
            end
            F_PUSH: begin
                // a zero width drops the item here
                if ((width_reg == '0) || !q_stat.full) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        mag_reg   <= mag_next;
        neg_reg   <= neg_next;
        pos_reg   <= pos_next;
        width_reg <= width_next;
        field_reg <= field_next;
    end

endmodule

@@ design/sdf_queue.sv @@
module sdf_queue #(
    parameter int ENTRY_W = 117
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               push,
    input  logic [ENTRY_W-1:0] push_data,
    input  logic               pop,
    output logic [ENTRY_W-1:0] head_data,
    output sdf_pkg::q_status_t q_stat
);

    logic [ENTRY_W-1:0] mem_reg [2];
    logic               wr_ptr_reg, wr_ptr_next;
    logic               rd_ptr_reg, rd_ptr_next;
    logic [1:0]         count_reg, count_next;

    assign head_data    = mem_reg[rd_ptr_reg];
    assign q_stat.full  = (count_reg == 2'd2);
    assign q_stat.empty = (count_reg == 2'd0);

    // pointer and fill count
    always_comb begin
        wr_ptr_next = wr_ptr_reg ^ push;
        rd_ptr_next = rd_ptr_reg ^ pop;
        count_next  = count_reg + {1'b0, push} - {1'b0, pop};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

@@ design/sdf_back.sv @@
module sdf_back #(
    parameter int FIELD_LEN = 16,
    parameter int POS_W     = $clog2(FIELD_LEN),
    parameter int WCNT_W    = $clog2(FIELD_LEN + 1)
) (
    input  logic                                        aclk,
    input  logic                                        aresetn,
    input  sdf_pkg::q_status_t                          q_stat,
    input  logic [WCNT_W-1:0]                           head_width,
    input  logic [FIELD_LEN-1:0][sdf_pkg::CHAR_W-1:0]   head_field,
    output logic                                        pop,
    output logic                                        out_valid,
    input  logic                                        out_ready,
    output logic [sdf_pkg::CHAR_W-1:0]                  out_char,
    output logic                                        out_last
);

    logic                                       active_reg, active_next;
    logic [WCNT_W-1:0]                          cnt_reg, cnt_next;
    logic [FIELD_LEN-1:0][sdf_pkg::CHAR_W-1:0]  field_reg, field_next;
    logic                                       out_xfer;
    logic                                       run_done;

    assign out_valid = active_reg;
    assign out_last  = (cnt_reg == WCNT_W'(1));
    assign out_char  = field_reg[POS_W'(cnt_reg - 1'b1)];
    assign out_xfer  = active_reg && out_ready;
    assign run_done  = out_xfer && out_last;
    assign pop       = !q_stat.empty && (!active_reg || run_done);

    // walk the field from the top requested position down to zero
    always_comb begin
        active_next = active_reg;
        cnt_next    = cnt_reg;
        field_next  = field_reg;
        if (pop) begin
            active_next = 1'b1;
            cnt_next    = head_width;
            field_next  = head_field;
        end else if (run_done) begin
            active_next = 1'b0;
        end else if (out_xfer) begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            active_reg <= 1'b0;
        end else begin
            active_reg <= active_next;
        end
        cnt_reg   <= cnt_next;
        field_reg <= field_next;
    end

endmodule

@@ design/sdf_checker.sv @@
module sdf_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [39:0] s_tdata,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [7:0]  m_tdata,
    input logic        m_tlast
);

    // a stalled character holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("output changed while stalled");

    // only digits, space, minus or the zero byte leave the block
    a_char_set: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata == 8'h00) || (m_tdata == 8'h20) || (m_tdata == 8'h2D)
                     || ((m_tdata >= 8'h30) && (m_tdata <= 8'h39)))
        else $error("character outside the field alphabet");

    // the last character of a run is position zero, never the zero byte or a space
    a_last_char: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tlast |-> (m_tdata >= 8'h30) && (m_tdata <= 8'h39))
        else $error("last character is not a digit");

    // no output right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind signed_decimal_field_formatter sdf_checker u_sdf_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

@@ bench/signed_decimal_field_formatter_test.sv @@
module signed_decimal_field_formatter_test;

    localparam int FIELD_LEN    = 16;
    localparam int PLAN_ROWS    = 22;
    localparam int RANDOM_ITEMS = 320;
    localparam int CALM_ITEMS   = 50;
    localparam int HOLD_AFTER   = 40;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 40;
    localparam int CYCLE_LIMIT  = 400000;
    localparam int PRINT_LIMIT  = 40;

    // one character of a formatted field, as the back end should send it
    typedef struct packed {
        logic [sdf_pkg::CHAR_W-1:0] code;
        logic                       last;
    } char_t;

    // directed row: the expected text is typed in only where it is obvious
    typedef struct {
        logic [sdf_pkg::NUMBER_W-1:0] number;
        logic [sdf_pkg::FWIDTH_W-1:0] width;
        bit                           typed;
        string                        text;
    } row_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [31:0] number, [36:32] field_width, [39:37] zero
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;         // [6:0] character, [7] zero
    logic        m_tlast;

    char_t expected_chars [$];
    row_t  plan [PLAN_ROWS];
    int    mismatches  = 0;
    int    items_sent  = 0;
    int    cycle_count = 0;
    bit    calm        = 1'b0;

    signed_decimal_field_formatter #(
        .FIELD_LEN(FIELD_LEN)
    ) u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always #2 aclk = ~aclk;

    task automatic report_mismatch(input string what);
        if (mismatches < PRINT_LIMIT) begin
            $display("mismatch @%0t: %s", $realtime, what);
        end
        mismatches++;
    endtask

    // builds the field for one number and queues the characters it emits
    function automatic void predict_characters(input logic [sdf_pkg::NUMBER_W-1:0] num,
                                               input logic [sdf_pkg::FWIDTH_W-1:0] width);
        logic [sdf_pkg::CHAR_W-1:0]   cells [FIELD_LEN];
        logic [sdf_pkg::NUMBER_W-1:0] mag;
        logic [sdf_pkg::NUMBER_W-1:0] digit;
        bit                           neg;
        int                           pos;
        int                           count;
        neg = num[sdf_pkg::NUMBER_W-1];
        mag = neg ? (~num + 32'd1) : num;
        for (int k = 0; k < FIELD_LEN; k++) begin
            cells[k] = sdf_pkg::CH_SPACE;
        end
        cells[FIELD_LEN-1] = sdf_pkg::CH_NUL;
        // digits from the least significant position upward
        pos = 0;
        do begin
            digit = mag % 32'd10;
            if (pos < FIELD_LEN - 1) begin
                cells[pos] = sdf_pkg::CH_ZERO + digit[sdf_pkg::CHAR_W-1:0];
            end
            pos++;
            mag = mag / 32'd10;
        end while (mag != 0);
        if (neg && pos < FIELD_LEN - 1) begin
            cells[pos] = sdf_pkg::CH_MINUS;
        end
        // widths beyond the field saturate
        count = (width > FIELD_LEN) ? FIELD_LEN : int'(width);
        for (int p = count - 1; p >= 0; p--) begin
            expected_chars.push_back('{cells[p], p == 0});
        end
    endfunction

    // numbers spread over digit counts, boundaries and extremes
    function automatic logic [sdf_pkg::NUMBER_W-1:0] pick_number();
        logic [sdf_pkg::NUMBER_W-1:0] v;
        logic [sdf_pkg::NUMBER_W-1:0] p10;
        int                           k;
        p10 = 32'd1;
        k = $urandom_range(1, 9);
        repeat (k) p10 = p10 * 32'd10;
        case ($urandom_range(0, 5))
            0: v = $urandom;
            1: v = $urandom_range(0, 99);
            2: v = p10 + $urandom_range(0, 2) - 32'd1;
            3: begin
                case ($urandom_range(0, 4))
                    0: v = 32'h8000_0000;
                    1: v = 32'h7FFF_FFFF;
                    2: v = 32'h0000_0000;
                    3: v = 32'hFFFF_FFFF;
                    default: v = 32'h8000_0001;
                endcase
                return v;
            end
            default: v = $urandom % p10;
        endcase
        if ($urandom_range(0, 1) == 1) begin
            v = -v;
        end
        return v;
    endfunction

    function automatic logic [sdf_pkg::FWIDTH_W-1:0] pick_width();
        case ($urandom_range(0, 9))
            0: return 5'd0;
            1: return 5'($urandom_range(17, 31));
            2: return 5'd16;
            default: return 5'($urandom_range(1, 15));
        endcase
    endfunction

    // offer one number and hold it until the block takes it
    task automatic offer(input logic [sdf_pkg::NUMBER_W-1:0] num,
                         input logic [sdf_pkg::FWIDTH_W-1:0] width);
        s_tdata  <= {3'b000, width, num};
        s_tvalid <= 1'b1;
        do @(posedge aclk); while (!s_tready);
        items_sent++;
    endtask

    task automatic sender_gap();
        if (!calm && $urandom_range(0, 3) == 0) begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge aclk);
        end
    endtask

    // stimulus: directed table, then random numbers, then drain
    initial begin : stimulus
        logic [sdf_pkg::NUMBER_W-1:0] num;
        logic [sdf_pkg::FWIDTH_W-1:0] width;
        byte                          ch;
        plan = '{
            '{32'd0,           5'd1,  1'b1, "0"},
            '{32'd0,           5'd0,  1'b1, ""},
            '{32'd7,           5'd5,  1'b1, "    7"},
            '{32'hFFFF_FFFF,   5'd2,  1'b1, "-1"},
            '{32'hFFFF_FFFF,   5'd3,  1'b1, " -1"},
            '{32'h7FFF_FFFF,   5'd15, 1'b1, "     2147483647"},
            '{32'h8000_0000,   5'd15, 1'b1, "    -2147483648"},
            '{32'h8000_0000,   5'd3,  1'b1, "648"},
            '{32'h8000_0000,   5'd16, 1'b0, ""},
            '{32'h7FFF_FFFF,   5'd31, 1'b0, ""},
            '{-32'sd12345,     5'd17, 1'b0, ""},
            '{32'd1000000000,  5'd10, 1'b1, "1000000000"},
            '{-32'sd999999999, 5'd10, 1'b1, "-999999999"},
            '{32'd9,           5'd16, 1'b0, ""},
            '{32'd10,          5'd2,  1'b1, "10"},
            '{-32'sd10,        5'd1,  1'b1, "0"},
            '{32'd123456789,   5'd0,  1'b1, ""},
            '{32'h5555_5555,   5'd12, 1'b0, ""},
            '{32'hAAAA_AAAA,   5'd13, 1'b0, ""},
            '{-32'sd5,         5'd16, 1'b0, ""},
            '{32'd0,           5'd31, 1'b0, ""},
            '{32'd99,          5'd4,  1'b1, "  99"}
        };
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // directed rows
        foreach (plan[i]) begin
            sender_gap();
            offer(plan[i].number, plan[i].width);
            if (plan[i].typed) begin
                for (int c = 0; c < plan[i].text.len(); c++) begin
                    ch = plan[i].text.getc(c);
                    expected_chars.push_back('{ch[sdf_pkg::CHAR_W-1:0],
                                               c == plan[i].text.len() - 1});
                end
            end else begin
                predict_characters(plan[i].number, plan[i].width);
            end
        end

        // random numbers, the tail without any idling
        for (int i = 0; i < RANDOM_ITEMS; i++) begin
            if (i >= RANDOM_ITEMS - CALM_ITEMS) begin
                calm = 1'b1;
            end
            sender_gap();
            num   = pick_number();
            width = pick_width();
            offer(num, width);
            predict_characters(num, width);
        end
        s_tvalid <= 1'b0;

        // drain, then give stray characters a chance to show up
        while (expected_chars.size() != 0) @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

    // receiver: random stall bursts, one long hold-off, steady when calm
    initial begin : sink_control
        bit held;
        held = 1'b0;
        @(posedge aclk iff aresetn);
        forever begin
            if (!held && items_sent >= PLAN_ROWS + HOLD_AFTER) begin
                held = 1'b1;
                m_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge aclk);
            end else if (!calm && $urandom_range(0, 5) == 0) begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 8)) @(posedge aclk);
            end else begin
                m_tready <= 1'b1;
                @(posedge aclk);
            end
        end
    end

    // compare each output transaction with the oldest expected character
    always @(posedge aclk) begin : check_output
        char_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h last %0b",
                                          m_tdata[sdf_pkg::CHAR_W-1:0], m_tlast));
            end else begin
                want = expected_chars.pop_front();
                if (m_tdata[sdf_pkg::CHAR_W-1:0] !== want.code) begin
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              m_tdata[sdf_pkg::CHAR_W-1:0], want.code));
                end
                if (m_tlast !== want.last) begin
                    report_mismatch($sformatf("tlast %0b, expected %0b", m_tlast, want.last));
                end
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin : watchdog
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

endmodule
